FILE: hdl/bca_pkg.sv
// Package for the bounded concurrency admission block.
// Holds field widths, kind and action codes, the job record and the
// control structs shared by the run table, wait queue and top level.
package bca_pkg;

    localparam int RUN_SLOTS_DEF  = 16;
    localparam int WAIT_DEPTH_DEF = 64;

    localparam int ACT_W  = 2;
    localparam int ID_W   = 22;
    localparam int UID_W  = 16;
    localparam int CID_W  = 16;
    localparam int KIND_W = 3;
    localparam int CFG_W  = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_EXEC = 2'd0,
        ACT_DONE = 2'd1,
        ACT_STOP = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        K_GRANT    = 3'd0,
        K_FINISHED = 3'd1,
        K_QUEUED   = 3'd2,
        K_REF_STOP = 3'd3,
        K_REF_FULL = 3'd4,
        K_SHUTDOWN = 3'd5
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0]  req;
        logic [UID_W-1:0] user;
        logic [CID_W-1:0] cmd;
    } t_job;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_run_ctl;

    typedef struct packed {
        logic push;
        logic pop;
    } t_wq_ctl;

endpackage

FILE: hdl/bca_run_table.sv
// Run table: one job record per slot in a memory with a registered read,
// per-slot valid flags and the count of running jobs.
// Depends on bca_pkg.
module bca_run_table
    import bca_pkg::*;
#(
    parameter int RUN_SLOTS = RUN_SLOTS_DEF,
    parameter int SLOT_W    = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1,
    parameter int CNT_W     = $clog2(RUN_SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_run_ctl          i_ctl,
    input  logic [SLOT_W-1:0] i_idx,
    input  t_job              i_wr_job,
    output logic              o_valid_at,
    output t_job              o_rd_job,
    output logic [CNT_W-1:0]  o_active
);

    t_job                 r_mem [RUN_SLOTS];
    logic [RUN_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]     r_active;
    t_job                 r_rd_job;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_idx] <= i_wr_job;
        end
        if (i_ctl.rd) begin
            r_rd_job <= r_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= '0;
        end else begin
            if (i_ctl.wr) begin
                r_valid[i_idx] <= 1'b1;
                r_active       <= r_active + CNT_W'(1);
            end else if (i_ctl.clr) begin
                r_valid[i_idx] <= 1'b0;
                if (r_active != '0) begin
                    r_active <= r_active - CNT_W'(1);
                end
            end
        end
    end

    assign o_valid_at = r_valid[i_idx];
    assign o_rd_job   = r_rd_job;
    assign o_active   = r_active;

endmodule

FILE: hdl/bca_wait_fifo.sv
// Wait queue: circular FIFO of job records in a memory, with head, tail
// and fill count; the head record is read into a register every cycle.
// Depends on bca_pkg.
module bca_wait_fifo
    import bca_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int PTR_W      = $clog2(WAIT_DEPTH),
    parameter int WC_W       = $clog2(WAIT_DEPTH + 1)
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_wq_ctl i_ctl,
    input  t_job    i_push_job,
    output t_job    o_head_job,
    output logic    o_empty,
    output logic    o_full
);

    t_job             r_mem [WAIT_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [WC_W-1:0]  r_count;
    t_job             r_head_job;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(WAIT_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_push_job;
        end
        r_head_job <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.push) begin
                r_tail <= wrap_inc(r_tail);
            end
            if (i_ctl.pop) begin
                r_head <= wrap_inc(r_head);
            end
            if (i_ctl.push && !i_ctl.pop) begin
                r_count <= r_count + WC_W'(1);
            end else if (i_ctl.pop && !i_ctl.push) begin
                r_count <= r_count - WC_W'(1);
            end
        end
    end

    assign o_head_job = r_head_job;
    assign o_empty    = (r_count == '0);
    assign o_full     = (r_count == WC_W'(WAIT_DEPTH));

endmodule

FILE: hdl/bounded_concurrency_admission.sv
// Bounded concurrency admission controller: at most max_active jobs run at
// once, the rest wait in a FIFO. Command-style item port, strobed results.
//
// Use: drive i_action, i_requester_id, i_user_id, i_command_id with start
// high; the item is taken at an edge where busy is low. Results appear on
// the o_ ports for one cycle each with o_res_valid high; o_last marks the
// final result of an item. An item gives zero, one or two results.
// The receiver cannot stall; results are never held back.
// Sequencing: a sequencer walks the run table one slot at a time through a
// single requester compare. Busy covers only the decide step for stop,
// queue, refuse and ignored items; an exec with room also scans from slot 0
// to the lowest free slot and grants into it. A done reads and compares each
// occupied slot in turn up to the match, then grants a waiting job into the
// lowest free slot, or runs the idle check when nothing matched or a notice
// follows. The last result shows in the first cycle with busy low.
// The user writes max_active with i_cfg_we only while idle; the block does
// not enforce it. Reset empties the run table and queue, clears stop state
// and sets max_active 1. After the shutdown notice every item is taken and
// ignored. Depends on bca_pkg, bca_run_table, bca_wait_fifo.
module bounded_concurrency_admission
    import bca_pkg::*;
#(
    parameter int RUN_SLOTS  = RUN_SLOTS_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ID_W-1:0]   i_requester_id,
    input  logic [UID_W-1:0]  i_user_id,
    input  logic [CID_W-1:0]  i_command_id,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_res_valid,
    output logic [KIND_W-1:0] o_kind,
    output logic [ID_W-1:0]   o_target_id,
    output logic [UID_W-1:0]  o_job_user_id,
    output logic [CID_W-1:0]  o_job_command_id,
    output logic              o_last
);

    localparam int SLOT_W = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RUN_SLOTS + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RUN_SLOTS - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_FREE   = 6'b000100,
        S_RD     = 6'b001000,
        S_CMP    = 6'b010000,
        S_END    = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_action           r_act, n_act;
    t_job              r_item, n_item;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_pop, n_pop;
    logic              r_halted, n_halted;
    logic              r_stopping, n_stopping;
    logic              r_stop_valid, n_stop_valid;
    logic [ID_W-1:0]   r_stop_req, n_stop_req;
    logic [CFG_W-1:0]  r_max_active;

    logic              r_out_valid, n_out_valid;
    t_kind             r_out_kind, n_out_kind;
    t_job              r_out_job, n_out_job;
    logic              r_out_last, n_out_last;

    t_run_ctl          run_ctl;
    logic              run_valid_at;
    t_job              run_rd_job;
    logic [CNT_W-1:0]  run_active;
    t_wq_ctl           wq_ctl;
    t_job              wq_head_job;
    logic              wq_empty;
    logic              wq_full;

    logic [CMP_W-1:0]  eff_max;
    logic [CMP_W-1:0]  active_ext;
    logic              has_room;
    logic              grant_next;
    logic              shut_next;
    logic              is_idle;

    bca_run_table #(
        .RUN_SLOTS (RUN_SLOTS),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    ) u_run (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (run_ctl),
        .i_idx      (r_idx),
        .i_wr_job   (r_item),
        .o_valid_at (run_valid_at),
        .o_rd_job   (run_rd_job),
        .o_active   (run_active)
    );

    bca_wait_fifo #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_wait (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (wq_ctl),
        .i_push_job (r_item),
        .o_head_job (wq_head_job),
        .o_empty    (wq_empty),
        .o_full     (wq_full)
    );

    // zero counts as one, values above the slot count saturate
    always_comb begin
        eff_max = CMP_W'(r_max_active);
        if (r_max_active == '0) begin
            eff_max = CMP_W'(1);
        end else if (CMP_W'(r_max_active) > CMP_W'(RUN_SLOTS)) begin
            eff_max = CMP_W'(RUN_SLOTS);
        end
    end

    assign active_ext = CMP_W'(run_active);
    assign has_room   = (active_ext < eff_max);
    assign is_idle    = (run_active == '0) && wq_empty;
    // after the matched slot is freed: active - 1 < max  <=>  active <= max
    assign grant_next = !wq_empty && (active_ext <= eff_max);
    assign shut_next  = !grant_next && r_stopping && wq_empty
                        && (run_active == CNT_W'(1));

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_item       = r_item;
        n_idx        = r_idx;
        n_pop        = r_pop;
        n_halted     = r_halted;
        n_stopping   = r_stopping;
        n_stop_valid = r_stop_valid;
        n_stop_req   = r_stop_req;
        n_out_valid  = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_job    = r_out_job;
        n_out_last   = r_out_last;
        run_ctl      = '0;
        wq_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act   = t_action'(i_action);
                    n_item  = '{req: i_requester_id, user: i_user_id, cmd: i_command_id};
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                n_idx   = '0;
                n_pop   = 1'b0;
                if (!r_halted) begin
                    unique case (r_act)
                        ACT_EXEC: begin
                            if (r_stopping) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = K_REF_STOP;
                                n_out_job   = r_item;
                                n_out_last  = 1'b1;
                            end else if (has_room) begin
                                n_state = S_FREE;
                            end else if (!wq_full) begin
                                wq_ctl.push = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_kind  = K_QUEUED;
                                n_out_job   = r_item;
                                n_out_last  = 1'b1;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_kind  = K_REF_FULL;
                                n_out_job   = r_item;
                                n_out_last  = 1'b1;
                            end
                        end
                        ACT_DONE: begin
                            n_state = S_RD;
                        end
                        ACT_STOP: begin
                            n_stopping = 1'b1;
                            if (!r_stop_valid) begin
                                n_stop_valid = 1'b1;
                                n_stop_req   = r_item.req;
                            end
                            if (is_idle) begin
                                n_halted    = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_kind  = K_SHUTDOWN;
                                n_out_job   = '{req: n_stop_req, user: '0, cmd: '0};
                                n_out_last  = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FREE: begin
                // a free slot is guaranteed while active is below the max
                if (!run_valid_at) begin
                    run_ctl.wr  = 1'b1;
                    wq_ctl.pop  = r_pop;
                    n_pop       = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_kind  = K_GRANT;
                    n_out_job   = r_item;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_RD: begin
                if (run_valid_at) begin
                    run_ctl.rd = 1'b1;
                    n_state    = S_CMP;
                end else if (r_idx == LAST_SLOT) begin
                    n_state = S_END;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_CMP: begin
                if (run_rd_job.req == r_item.req) begin
                    run_ctl.clr = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = K_FINISHED;
                    n_out_job   = run_rd_job;
                    n_out_last  = !(grant_next || shut_next);
                    if (grant_next) begin
                        // oldest waiting job takes the lowest free slot
                        n_item  = wq_head_job;
                        n_pop   = 1'b1;
                        n_idx   = '0;
                        n_state = S_FREE;
                    end else if (shut_next) begin
                        n_state = S_END;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (r_idx == LAST_SLOT) begin
                    n_state = S_END;
                end else begin
                    n_idx   = r_idx + SLOT_W'(1);
                    n_state = S_RD;
                end
            end
            S_END: begin
                n_state = S_IDLE;
                if (r_stopping && is_idle) begin
                    n_halted    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = K_SHUTDOWN;
                    n_out_job   = '{req: r_stop_req, user: '0, cmd: '0};
                    n_out_last  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pop        <= 1'b0;
            r_halted     <= 1'b0;
            r_stopping   <= 1'b0;
            r_stop_valid <= 1'b0;
            r_stop_req   <= '0;
            r_max_active <= CFG_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pop        <= n_pop;
            r_halted     <= n_halted;
            r_stopping   <= n_stopping;
            r_stop_valid <= n_stop_valid;
            r_stop_req   <= n_stop_req;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_max_active <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_out_kind <= n_out_kind;
        r_out_job  <= n_out_job;
        r_out_last <= n_out_last;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_res_valid      = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_target_id      = r_out_job.req;
    assign o_job_user_id    = r_out_job.user;
    assign o_job_command_id = r_out_job.cmd;
    assign o_last           = r_out_last;

endmodule

FILE: hdl/bca_checker.sv
// Port-level checker for the admission block, bound to the top level.
// Depends on bca_pkg and bounded_concurrency_admission.
module bca_checker
    import bca_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_res_valid,
    input logic [KIND_W-1:0] o_kind,
    input logic [UID_W-1:0]  o_job_user_id,
    input logic [CID_W-1:0]  o_job_command_id,
    input logic              o_last
);

    // an accepted item always occupies the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // results only come out of work in progress
    a_res_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result without a busy cycle before it");

    // a non-final result means another is still pending
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_last |-> busy)
        else $error("block idle with a result still owed");

    // the final result frees the block
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_last |-> !busy)
        else $error("block still busy after final result");

    a_shutdown_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_kind == K_SHUTDOWN) |->
            (o_job_user_id == '0) && (o_job_command_id == '0))
        else $error("shutdown notice carries job ids");

endmodule

bind bounded_concurrency_admission bca_checker u_bca_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_res_valid      (o_res_valid),
    .o_kind           (o_kind),
    .o_job_user_id    (o_job_user_id),
    .o_job_command_id (o_job_command_id),
    .o_last           (o_last)
);
